[hw/rtl/scmd_pkg.sv]
`default_nettype none
package scmd_pkg;

	localparam int DelayDepth  = 2048;
	localparam int PtrBits     = $clog2(DelayDepth);
	localparam int SampleBits  = 24;
	localparam int SineEntries = 256;
	localparam int SineIdxBits = $clog2(SineEntries);
	localparam int PhaseBits   = 24;

	localparam logic [2:0] REG_BASE_DELAY   = 3'd0;
	localparam logic [2:0] REG_MOD_DEPTH    = 3'd1;
	localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
	localparam logic [2:0] REG_WET_MIX      = 3'd4;

	typedef struct packed {
		logic signed [SampleBits-1:0] left_in;
		logic signed [SampleBits-1:0] right_in;
		logic                         is_stereo;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] left_out;
		logic signed [SampleBits-1:0] right_out;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] data;
	} cfg_beat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DELAY,
		ST_ADDR,
		ST_READ,
		ST_INTERP,
		ST_MIX,
		ST_NEXT,
		ST_WRITE,
		ST_OUT
	} ctrl_state_t;

	// one channel pass: ch selects right
	typedef struct packed {
		logic clear;
		logic load;
		logic ch;
		logic calc_delay;
		logic calc_addr;
		logic latch_taps;
		logic calc_interp;
		logic calc_mix;
		logic write_store;
		logic advance;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_stereo;
		logic clear_last;
	} dp_status_t;

	// quarter-wave sine, Q1.15, from a fixed-point Taylor series on a Q30 angle
	function automatic logic [(SineEntries+1)*16-1:0] build_sine();
		logic [(SineEntries+1)*16-1:0] tab;
		longint unsigned               x, term;
		longint                        sum, r;
		tab = '0;
		for (int k = 0; k <= SineEntries; k++) begin
			x    = 64'd1686629713 * 64'(k) / 64'(SineEntries);
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n[0])
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			r = longint'(($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30);
			if (r > 32767)
				r = 32767;
			tab[k*16 +: 16] = 16'(r);
		end
		return tab;
	endfunction

	localparam logic [(SineEntries+1)*16-1:0] SineRom = build_sine();

endpackage
`default_nettype wire

[hw/rtl/scmd_ram.sv]
`default_nettype none
module scmd_ram #(
	parameter int Width = 24,
	parameter int Depth = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/scmd_ctrl.sv]
`default_nettype none
module scmd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output scmd_pkg::dp_cmd_t        cmd,
	input  wire scmd_pkg::dp_status_t status
);
	import scmd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        ch_q, ch_d;
	logic        ov_q, ov_d;
	logic        taps_q, taps_d;

	// taps: second read beat pending (two reads per channel)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ch_q    <= 1'b0;
			ov_q    <= 1'b0;
			taps_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			ov_q    <= ov_d;
			taps_q  <= taps_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d  = state_q;
		ch_d     = ch_q;
		taps_d   = taps_q;
		ov_d     = ov_q && out_stall;
		cmd      = '0;
		cmd.ch   = ch_q;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					ch_d     = 1'b0;
					state_d  = ST_DELAY;
				end
			end
			ST_DELAY: begin
				cmd.calc_delay = 1'b1;
				state_d        = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.calc_addr = 1'b1;
				taps_d        = 1'b0;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.latch_taps = taps_q;
				cmd.calc_addr  = 1'b0;
				taps_d         = 1'b1;
				if (taps_q)
					state_d = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.latch_taps  = 1'b1;
				cmd.calc_interp = 1'b1;
				state_d         = ST_MIX;
			end
			ST_MIX: begin
				cmd.calc_mix = 1'b1;
				state_d      = ST_NEXT;
			end
			ST_NEXT: begin
				if (!ch_q && status.is_stereo) begin
					ch_d    = 1'b1;
					state_d = ST_DELAY;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_store = 1'b1;
				cmd.advance     = 1'b1;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					ov_d         = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ch_right_stereo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DELAY && ch_q) |-> status.is_stereo)
		else $error("right pass in mono");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DELAY && !ch_q)
		else $error("load did not start left pass");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped");
`endif
endmodule
`default_nettype wire

[hw/rtl/scmd_dp.sv]
`default_nettype none
module scmd_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scmd_pkg::in_item_t   in_item,
	input  wire scmd_pkg::cfg_beat_t  cfg,
	input  wire logic                 cfg_we,
	input  wire scmd_pkg::dp_cmd_t    cmd,
	output scmd_pkg::dp_status_t      status,
	output scmd_pkg::out_item_t       out_item
);
	import scmd_pkg::*;

	localparam int LoClamp = 256;
	localparam int HiClamp = (DelayDepth - 1) * 256;
	localparam int DBits   = $clog2(HiClamp + 1) + 1;

	logic [17:0] base_q, depth_q;
	logic [20:0] step_q;
	logic [23:0] offs_q;
	logic [16:0] mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 18'd1764;
			depth_q <= 18'd33868;
			step_q  <= 21'd380;
			offs_q  <= 24'd4194304;
			mix_q   <= 17'd32768;
		end else if (cfg_we) begin
			case (cfg.index)
				REG_BASE_DELAY:   base_q  <= cfg.data[17:0];
				REG_MOD_DEPTH:    depth_q <= cfg.data[17:0];
				REG_PHASE_STEP:   step_q  <= cfg.data[20:0];
				REG_PHASE_OFFSET: offs_q  <= cfg.data;
				REG_WET_MIX:      mix_q   <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	logic [PtrBits-1:0]   wp_q;
	logic [PhaseBits-1:0] phase_q;

	// clearing pass walks the pointer over every entry and wraps it back to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			phase_q <= '0;
		end else if (cmd.clear) begin
			wp_q <= wp_q + 1'b1;
		end else if (cmd.advance) begin
			wp_q    <= wp_q + 1'b1;
			phase_q <= phase_q + PhaseBits'(step_q);
		end
	end

	in_item_t in_q;
	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= in_item;
	end
	assign status = '{is_stereo: in_q.is_stereo, clear_last: &wp_q};

	// delay computation
	logic [PhaseBits-1:0]   ph;
	logic [1:0]             quad;
	logic [SineIdxBits-1:0] idx;
	logic [SineIdxBits:0]   tidx;
	logic [15:0]            sv;
	logic [16:0]            u;
	logic [34:0]            prod;
	logic [DBits-1:0]       d_full;
	logic [DBits-1:0]       d_s1;

	always_comb begin
		ph   = cmd.ch ? phase_q + offs_q : phase_q;
		quad = ph[PhaseBits-1 -: 2];
		idx  = ph[PhaseBits-3 -: SineIdxBits];
		tidx = quad[0] ? (SineIdxBits+1)'(SineEntries) - {1'b0, idx} : {1'b0, idx};
		sv   = SineRom[{tidx, 4'b0} +: 16];
		u    = quad[1] ? 17'd32768 - {1'b0, sv} : 17'd32768 + {1'b0, sv};
		prod = depth_q * u;
		d_full = DBits'(base_q) + DBits'(prod[34:16]);
		if (d_full < DBits'(LoClamp))
			d_full = DBits'(LoClamp);
		if (d_full > DBits'(HiClamp))
			d_full = DBits'(HiClamp);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_delay)
			d_s1 <= d_full;
	end

	logic [PtrBits-1:0] whole;
	logic [7:0]         frac_q;
	logic [PtrBits-1:0] i0_q, i1_q, raddr;
	logic               sel1_q;

	assign whole = d_s1[8 +: PtrBits];

	always_ff @(posedge clk) begin
		if (cmd.calc_addr) begin
			frac_q <= d_s1[7:0];
			i0_q   <= wp_q - whole;
			i1_q   <= wp_q - whole - 1'b1;
		end
	end

	// first read beat fetches i0, second i1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel1_q <= 1'b0;
		else if (cmd.calc_addr)
			sel1_q <= 1'b0;
		else
			sel1_q <= 1'b1;
	end
	assign raddr = sel1_q ? i1_q : i0_q;

	logic [SampleBits-1:0] lrd, rrd, lwd, rwd;
	logic                  we_l, we_r;
	assign we_l = cmd.clear || cmd.write_store;
	assign we_r = cmd.clear || (cmd.write_store && in_q.is_stereo);
	assign lwd  = cmd.clear ? '0 : in_q.left_in;
	assign rwd  = cmd.clear ? '0 : in_q.right_in;

	scmd_ram #(.Width(SampleBits), .Depth(DelayDepth)) u_lram (
		.clk(clk), .we(we_l), .waddr(wp_q), .wdata(lwd),
		.raddr(raddr), .rdata(lrd));
	scmd_ram #(.Width(SampleBits), .Depth(DelayDepth)) u_rram (
		.clk(clk), .we(we_r), .waddr(wp_q), .wdata(rwd),
		.raddr(raddr), .rdata(rrd));

	logic signed [SampleBits-1:0] rd, x0_q;
	assign rd = cmd.ch ? rrd : lrd;

	always_ff @(posedge clk) begin
		if (cmd.latch_taps && !cmd.calc_interp)
			x0_q <= rd;
	end

	// second tap is used straight from the RAM in the interpolate beat
	logic signed [SampleBits+9:0] acc;
	logic signed [SampleBits-1:0] wet_s2;
	always_comb begin
		acc = x0_q * $signed({1'b0, 9'd256 - {1'b0, frac_q}})
			+ rd * $signed({2'b0, frac_q}) + 34'sd128;
	end
	always_ff @(posedge clk) begin
		if (cmd.calc_interp)
			wet_s2 <= SampleBits'(acc >>> 8);
	end

	logic [16:0]                  m;
	logic signed [SampleBits+18:0] y;
	logic signed [SampleBits+2:0]  ys;
	logic signed [SampleBits-1:0]  dry, sat;
	always_comb begin
		m   = mix_q[16] ? 17'd65536 : mix_q;
		dry = cmd.ch ? in_q.right_in : in_q.left_in;
		y   = dry * $signed({1'b0, 17'd65536 - m}) + wet_s2 * $signed({1'b0, m})
			+ 43'sd32768;
		ys  = (SampleBits+3)'(y >>> 16);
		if (ys > $signed((SampleBits+3)'(2**(SampleBits-1) - 1)))
			sat = {1'b0, {(SampleBits-1){1'b1}}};
		else if (ys < -$signed((SampleBits+3)'(2**(SampleBits-1))))
			sat = {1'b1, {(SampleBits-1){1'b0}}};
		else
			sat = SampleBits'(ys);
	end

	logic signed [SampleBits-1:0] lres_q, rres_q;
	always_ff @(posedge clk) begin
		if (cmd.load)
			rres_q <= '0;
		if (cmd.calc_mix && !cmd.ch)
			lres_q <= sat;
		if (cmd.calc_mix && cmd.ch)
			rres_q <= sat;
		if (cmd.out_load) begin
			out_item.left_out  <= lres_q;
			out_item.right_out <= rres_q;
		end
	end

`ifndef SYNTHESIS
	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_addr |-> (d_s1 >= DBits'(LoClamp) && d_s1 <= DBits'(HiClamp)))
		else $error("delay outside clamp");
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.write_store || cmd.load || cmd.advance))
		else $error("item work during clearing pass");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.advance |=> $stable(phase_q))
		else $error("LFO phase moved without advance");
`endif
endmodule
`default_nettype wire

[hw/rtl/stereo_chorus_modulated_delay_unit.sv]
`default_nettype none
// One item is processed at a time: input stays stalled until the result of the
// last item is loaded for output; the pace is set by the one shared
// delay/interpolate/mix datapath walked once per channel by the controller.
// Reset: registers return to their defaults, pointer and LFO phase to zero; a
// clearing pass then zeroes both delay stores while input is stalled.
module stereo_chorus_modulated_delay_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire scmd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output scmd_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire scmd_pkg::cfg_beat_t cfg_data
);
	import scmd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	scmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .status(status));

	scmd_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_data), .cfg(cfg_data), .cfg_we(cfg_valid && cfg_ready),
		.cmd(cmd), .status(status), .out_item(out_data));
endmodule
`default_nettype wire

[tb/tb_stereo_chorus_modulated_delay_unit.sv]
`default_nettype none
module tb_stereo_chorus_modulated_delay_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import scmd_pkg::*;

	localparam logic [2:0] RegUnused = 3'd5;
	localparam int StallLimit = 20000;
	localparam int SettleCycles = 40;

	class chorus_scoreboard;
		logic signed [SampleBits-1:0] left_mem [DelayDepth];
		logic signed [SampleBits-1:0] right_mem [DelayDepth];
		logic [PtrBits-1:0] wr_ptr;
		logic [PhaseBits-1:0] phase;
		logic [17:0] base_delay, mod_depth;
		logic [20:0] phase_step;
		logic [23:0] phase_offset;
		logic [16:0] wet_mix;
		longint sine_tab [SineEntries+1];
		out_item_t pending_out [$];
		int errors;
		int n_stereo, n_mono, n_checked;

		function new();
			longint unsigned x, term;
			longint sum, r;
			for (int k = 0; k <= SineEntries; k++) begin
				x = 64'd1686629713 * k / SineEntries;
				term = x;
				sum = longint'(x);
				for (int n = 1; n <= 6; n++) begin
					term = (term * x) >> 30;
					term = (term * x) >> 30;
					term = term / ((2 * n) * (2 * n + 1));
					if (n % 2) sum -= longint'(term);
					else sum += longint'(term);
				end
				if (sum < 0) sum = 0;
				r = (sum * 32767 + (64'd1 << 29)) >>> 30;
				if (r > 32767) r = 32767;
				sine_tab[k] = r;
			end
			for (int i = 0; i < DelayDepth; i++) begin
				left_mem[i] = '0;
				right_mem[i] = '0;
			end
			wr_ptr = '0;
			phase = '0;
			base_delay = 18'd1764;
			mod_depth = 18'd33868;
			phase_step = 21'd380;
			phase_offset = 24'd4194304;
			wet_mix = 17'd32768;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				REG_BASE_DELAY: begin
					base_delay = val[17:0];
				end
				REG_MOD_DEPTH: begin
					mod_depth = val[17:0];
				end
				REG_PHASE_STEP: begin
					phase_step = val[20:0];
				end
				REG_PHASE_OFFSET: begin
					phase_offset = val;
				end
				REG_WET_MIX: begin
					wet_mix = val[16:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint sine_at(logic [PhaseBits-1:0] ph);
			int idx;
			longint v;
			idx = int'(ph[21:14]);
			v = ph[22] ? sine_tab[SineEntries - idx] : sine_tab[idx];
			return ph[23] ? -v : v;
		endfunction

		function longint tap(bit right, logic [PhaseBits-1:0] ph);
			longint d, x0, x1;
			int whole, frac, i0, i1;
			d = longint'(base_delay) + ((longint'(mod_depth) * (32768 + sine_at(ph))) >>> 16);
			if (d < 256) d = 256;
			if (d > (DelayDepth - 1) * 256) d = (DelayDepth - 1) * 256;
			whole = int'(d >>> 8);
			frac = int'(d % 256);
			i0 = (wr_ptr + DelayDepth - whole) % DelayDepth;
			i1 = (wr_ptr + 2 * DelayDepth - whole - 1) % DelayDepth;
			x0 = right ? right_mem[i0] : left_mem[i0];
			x1 = right ? right_mem[i1] : left_mem[i1];
			return (x0 * (256 - frac) + x1 * frac + 128) >>> 8;
		endfunction

		function logic signed [SampleBits-1:0] mixed(longint dry, longint wet);
			longint m, y;
			m = (wet_mix > 17'd65536) ? 65536 : longint'(wet_mix);
			y = (dry * (65536 - m) + wet * m + 32768) >>> 16;
			if (y > 8388607) y = 8388607;
			if (y < -8388608) y = -8388608;
			return y[SampleBits-1:0];
		endfunction

		function void note_sample(in_item_t it);
			out_item_t e;
			e.left_out = mixed(longint'(it.left_in), tap(1'b0, phase));
			e.right_out = '0;
			if (it.is_stereo) begin
				e.right_out = mixed(longint'(it.right_in), tap(1'b1, phase + phase_offset));
				right_mem[wr_ptr] = it.right_in;
				n_stereo++;
			end else begin
				n_mono++;
			end
			left_mem[wr_ptr] = it.left_in;
			wr_ptr = wr_ptr + 1'b1;
			phase = phase + phase_step;
			pending_out.push_back(e);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected result L=%0d R=%0d", $time, got.left_out, got.right_out);
				errors++;
				return;
			end
			e = pending_out.pop_front();
			n_checked++;
			if (got.left_out !== e.left_out) begin
				$display("%0t: left_out expected %0d actual %0d", $time, e.left_out, got.left_out);
				errors++;
			end
			if (got.right_out !== e.right_out) begin
				$display("%0t: right_out expected %0d actual %0d",
					$time, e.right_out, got.right_out);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_beat_t cfg_data = '0;

	chorus_scoreboard sb = new();
	int send_gap_pct = 20;
	int recv_stall_pct = 20;
	bit quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int n_settings = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stereo_chorus_modulated_delay_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// result side: check accepted beats, then pick the next stall state
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < recv_stall_pct) begin
			stall_left <= $urandom_range(12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
		cfg_data <= '{index: idx, data: val};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [23:0] l, logic [23:0] r, bit st);
		in_item_t it;
		int gap;
		it.left_in = l;
		it.right_in = r;
		it.is_stereo = st;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_sample(it);
		if (!quiet && $urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_out.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic apply_setting(int bd, int md, int ps, int po, int wm);
		drain();
		write_cfg(REG_BASE_DELAY, 24'(bd));
		write_cfg(REG_MOD_DEPTH, 24'(md));
		write_cfg(REG_PHASE_STEP, 24'(ps));
		write_cfg(REG_PHASE_OFFSET, 24'(po));
		write_cfg(REG_WET_MIX, 24'(wm));
		n_settings++;
	endtask

	task automatic random_run(int n);
		logic [23:0] l, r;
		for (int i = 0; i < n; i++) begin
			l = 24'($urandom);
			r = 24'($urandom);
			// sprinkle full-scale values so the mix sees its corners
			if ($urandom_range(15) == 0) l = $urandom_range(1) ? 24'h7fffff : 24'h800000;
			if ($urandom_range(15) == 0) r = $urandom_range(1) ? 24'h7fffff : 24'h800000;
			send_sample(l, r, $urandom_range(3) != 0);
			if (i == n / 2 && $urandom_range(3) == 0) drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extremes, mono and stereo
		send_sample(24'h7fffff, 24'h800000, 1'b1);
		send_sample(24'h800000, 24'h7fffff, 1'b1);
		send_sample(24'h000000, 24'h000000, 1'b0);
		send_sample(24'hffffff, 24'h000001, 1'b1);
		send_sample(24'h555555, 24'haaaaaa, 1'b0);
		send_sample(24'haaaaaa, 24'h555555, 1'b1);
		drain();
		write_cfg(RegUnused, 24'hffffff);
		// one-sample delay, frozen LFO, full wet: echoes the previous beat
		apply_setting(256, 0, 0, 0, 65536);
		send_sample(24'h7fffff, 24'h7fffff, 1'b1);
		send_sample(24'h800000, 24'h800000, 1'b1);
		send_sample(24'h7fffff, 24'h123456, 1'b0);
		send_sample(24'h800000, 24'h654321, 1'b1);
		// below-range delay and wet above full
		apply_setting(0, 0, 0, 8388608, 131071);
		send_sample(24'h400000, 24'hc00000, 1'b1);
		send_sample(24'hc00000, 24'h400000, 1'b1);
		send_sample(24'h000001, 24'hfffffe, 1'b0);
		// long base delay with deep modulation, dry output only
		apply_setting(261888, 131072, 1048576, 16777215, 0);
		send_sample(24'h7fffff, 24'h800000, 1'b1);
		send_sample(24'h800000, 24'h7fffff, 1'b1);

		apply_setting(1764, 33868, 380, 4194304, 32768);
		random_run(250);
		apply_setting(256, 131072, 1048576, 8388608, 65536);
		random_run(250);
		recv_stall_pct = 0;
		send_gap_pct = 0;
		apply_setting(300, 2000, 20000, 16777215, 12345);
		random_run(250);
		recv_stall_pct = 40;
		send_gap_pct = 40;
		apply_setting(261888, 0, 0, 0, 131071);
		random_run(200);
		apply_setting($urandom_range(256, 20000), $urandom_range(131072),
			$urandom_range(1048576), $urandom_range(8388608), $urandom_range(65536));
		random_run(300);
		recv_stall_pct = 20;
		send_gap_pct = 20;
		apply_setting(1000, 65536, 777777, 1234567, 0);
		random_run(300);
		apply_setting(5000, 100000, 3, 4194304, 40000);
		quiet = 1'b1;
		random_run(330);

		drain();
		$display("Checked %0d results (%0d stereo, %0d mono beats) over %0d register settings",
			sb.n_checked, sb.n_stereo, sb.n_mono, n_settings);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

[stereo_chorus_modulated_delay_unit.f]
hw/rtl/scmd_pkg.sv
hw/rtl/scmd_ram.sv
hw/rtl/scmd_ctrl.sv
hw/rtl/scmd_dp.sv
hw/rtl/stereo_chorus_modulated_delay_unit.sv
tb/tb_stereo_chorus_modulated_delay_unit.sv
